// ===== src/cbe_pkg.sv =====
package cbe_pkg;

  localparam int FRAC = 16;
  localparam int ITERS = 8;
  localparam int ITW = 4;
  localparam int VW = 24;
  localparam int DW = 40;
  localparam int QW = 40;
  localparam logic signed [VW-1:0] ONE_Q = 24'sd65536;
  localparam logic signed [VW-1:0] EPS = 24'sd66;

  localparam logic [1:0] REG_P1X = 2'd0;
  localparam logic [1:0] REG_P1Y = 2'd1;
  localparam logic [1:0] REG_P2X = 2'd2;
  localparam logic [1:0] REG_P2Y = 2'd3;

  typedef enum logic [3:0] {
    OP_T2,
    OP_UU,
    OP_K1,
    OP_K2,
    OP_T3,
    OP_KA,
    OP_KB,
    OP_UT,
    OP_DA,
    OP_DB,
    OP_DC
  } op_t;

  typedef struct packed {
    logic load;
    logic mul_go;
    op_t  op;
    logic sel_y;
    logic clr_acc;
    logic mk_diff;
    logic div_go;
    logic upd_t;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic trivial;
    logic mul_done;
    logic div_done;
    logic conv;
    logic dzero;
  } sts_t;

  function automatic logic signed [VW-1:0] rnd16(input logic signed [2*VW-1:0] p);
    logic [2*VW-1:0] m;
    logic [2*VW-1:0] r;
    begin
      m = p[2*VW-1] ? (~p + 1'b1) : p;
      r = (m + 48'd32768) >> FRAC;
      rnd16 = p[2*VW-1] ? VW'(-$signed(r)) : VW'($signed(r));
    end
  endfunction

endpackage

// ===== src/cbe_ctrl.sv =====
module cbe_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  cbe_pkg::sts_t  sts,
  output cbe_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_MUL, S_WAIT, S_CHK, S_DIV, S_DWAIT, S_OUT, S_DONE
  } state_t;

  state_t state;
  cbe_pkg::op_t op;
  logic sel_y;
  logic deriv;
  logic [cbe_pkg::ITW:0] iter;

  always_comb begin
    cmd = '0;
    cmd.op = op;
    cmd.sel_y = sel_y;
    in_ready = (state == S_IDLE);
    cmd.load = in_valid && in_ready;
    out_valid = (state == S_DONE);
    case (state)
      S_START: cmd.clr_acc = 1'b1;
      S_MUL:   cmd.mul_go = 1'b1;
      S_CHK:   cmd.mk_diff = !deriv;
      S_DIV:   cmd.div_go = 1'b1;
      S_DWAIT: cmd.upd_t = sts.div_done;
      S_OUT:   cmd.out_ld = 1'b1;
      default: ;
    endcase
  end

  // Sequence of products: bez (T2..KB), then derivative (UT..DC).
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= cbe_pkg::OP_T2;
      sel_y <= 1'b0;
      deriv <= 1'b0;
      iter <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          if (sts.trivial) state <= S_DONE;
          else begin
            state <= S_START;
            iter <= '0;
            sel_y <= 1'b0;
          end
        end
        S_START: begin
          op <= cbe_pkg::OP_T2;
          deriv <= 1'b0;
          state <= S_MUL;
        end
        S_MUL: state <= S_WAIT;
        S_WAIT: if (sts.mul_done) begin
          if (op == cbe_pkg::OP_KB) begin
            if (sel_y) state <= S_OUT;
            else if (iter == (cbe_pkg::ITW+1)'(cbe_pkg::ITERS)) begin
              sel_y <= 1'b1;
              state <= S_START;
            end else state <= S_CHK;
          end else if (op == cbe_pkg::OP_DC) state <= S_CHK;
          else begin
            op <= cbe_pkg::op_t'(op + 4'd1);
            state <= S_MUL;
          end
        end
        S_CHK: begin
          if (!deriv) begin
            if (sts.conv) begin
              sel_y <= 1'b1;
              state <= S_START;
            end else begin
              deriv <= 1'b1;
              op <= cbe_pkg::OP_UT;
              state <= S_MUL;
            end
          end else if (sts.dzero) begin
            sel_y <= 1'b1;
            state <= S_START;
          end else state <= S_DIV;
        end
        S_DIV: state <= S_DWAIT;
        S_DWAIT: if (sts.div_done) begin
          iter <= iter + 1'b1;
          state <= S_START;
        end
        S_OUT: state <= S_DONE;
        S_DONE: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/cbe_div.sv =====
module cbe_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                go,
  input  logic signed [cbe_pkg::DW-1:0]       num,
  input  logic signed [cbe_pkg::VW-1:0]       den,
  output logic                                done,
  output logic signed [cbe_pkg::QW-1:0]       quo
);

  logic [cbe_pkg::DW-1:0] q;
  logic [cbe_pkg::VW:0] rem;
  logic [cbe_pkg::VW-1:0] dm;
  logic neg;
  logic busy;
  logic [5:0] cnt;
  logic [cbe_pkg::VW:0] trial;

  assign trial = {rem[cbe_pkg::VW-1:0], q[cbe_pkg::DW-1]} - {1'b0, dm};

  // Restoring divide, one quotient bit per cycle, magnitudes.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt <= 6'(cbe_pkg::DW);
        rem <= '0;
        q <= num[cbe_pkg::DW-1] ? ~num + 1'b1 : num;
        dm <= den[cbe_pkg::VW-1] ? ~den + 1'b1 : den;
        neg <= num[cbe_pkg::DW-1] ^ den[cbe_pkg::VW-1];
      end else if (busy) begin
        if (!trial[cbe_pkg::VW]) begin
          rem <= trial;
          q <= {q[cbe_pkg::DW-2:0], 1'b1};
        end else begin
          rem <= {rem[cbe_pkg::VW-1:0], q[cbe_pkg::DW-1]};
          q <= {q[cbe_pkg::DW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg ? -$signed(q) : $signed(q);

endmodule

// ===== src/cbe_dp.sv =====
module cbe_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  cbe_pkg::cmd_t          cmd,
  output cbe_pkg::sts_t          sts,
  input  logic signed [17:0]     x_in,
  input  logic [16:0]            p1_x,
  input  logic signed [18:0]     p1_y,
  input  logic [16:0]            p2_x,
  input  logic signed [18:0]     p2_y,
  output logic signed [18:0]     y_out
);

  localparam int VW = cbe_pkg::VW;

  logic signed [VW-1:0] xc, x, t, u, t2, uu, k1, k2, ut, acc, m_a, m_b, r, diff;
  logic signed [VW-1:0] a, b;
  logic signed [2*VW-1:0] prod;
  logic signed [VW+3:0] sum;
  logic signed [cbe_pkg::DW-1:0] num;
  logic signed [cbe_pkg::QW-1:0] quo;
  logic signed [cbe_pkg::QW:0] tn;
  logic div_done;
  logic mul_v;
  logic signed [VW-1:0] ax, bx;

  assign ax = VW'($signed({1'b0, p1_x}));
  assign bx = VW'($signed({1'b0, p2_x}));
  assign a = cmd.sel_y ? VW'(p1_y) : ax;
  assign b = cmd.sel_y ? VW'(p2_y) : bx;
  assign u = cbe_pkg::ONE_Q - t;

  always_comb begin
    if (x_in < 18'sd0) xc = '0;
    else if (x_in > 18'sd65536) xc = cbe_pkg::ONE_Q;
    else xc = VW'(x_in);
  end

  assign sts.trivial = (xc == '0) || (xc == cbe_pkg::ONE_Q);

  always_comb begin
    case (cmd.op)
      cbe_pkg::OP_T2: begin m_a = t;  m_b = t;  end
      cbe_pkg::OP_UU: begin m_a = u;  m_b = u;  end
      cbe_pkg::OP_K1: begin m_a = uu; m_b = t;  end
      cbe_pkg::OP_K2: begin m_a = u;  m_b = t2; end
      cbe_pkg::OP_T3: begin m_a = t2; m_b = t;  end
      cbe_pkg::OP_KA: begin m_a = k1; m_b = a;  end
      cbe_pkg::OP_KB: begin m_a = k2; m_b = b;  end
      cbe_pkg::OP_UT: begin m_a = u;  m_b = t;  end
      cbe_pkg::OP_DA: begin m_a = uu; m_b = ax; end
      cbe_pkg::OP_DB: begin m_a = ut; m_b = bx - ax; end
      default:        begin m_a = t2; m_b = cbe_pkg::ONE_Q - bx; end
    endcase
  end

  // Product registered, then rounded and stored in a term register or accumulated next cycle.
  always_ff @(posedge clk) begin
    if (rst) mul_v <= 1'b0;
    else mul_v <= cmd.mul_go;
    prod <= m_a * m_b;
  end
  assign r = cbe_pkg::rnd16(prod);

  always_comb begin
    case (cmd.op)
      cbe_pkg::OP_KA, cbe_pkg::OP_KB, cbe_pkg::OP_DA, cbe_pkg::OP_DC:
        sum = (VW+4)'(acc) + (VW+4)'(3) * (VW+4)'(r);
      cbe_pkg::OP_DB: sum = (VW+4)'(acc) + (VW+4)'(6) * (VW+4)'(r);
      cbe_pkg::OP_T3: sum = (VW+4)'(acc) + (VW+4)'(r);
      default: sum = (VW+4)'(acc);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x <= xc;
      t <= xc;
    end
    if (cmd.clr_acc) acc <= '0;
    if (mul_v) begin
      case (cmd.op)
        cbe_pkg::OP_T2: t2 <= r;
        cbe_pkg::OP_UU: uu <= r;
        cbe_pkg::OP_K1: k1 <= r;
        cbe_pkg::OP_K2: k2 <= r;
        cbe_pkg::OP_UT: begin ut <= r; acc <= '0; end
        default: acc <= VW'(sum);
      endcase
    end
    if (cmd.mk_diff) diff <= acc - x;
    if (cmd.upd_t) begin
      if (tn < 0) t <= '0;
      else if (tn > (cbe_pkg::QW+1)'(cbe_pkg::ONE_Q)) t <= cbe_pkg::ONE_Q;
      else t <= VW'(tn);
    end
    if (cmd.out_ld) begin
      if (cmd.sel_y && acc > VW'(131072)) y_out <= 19'sd131072;
      else if (acc < -VW'(131072)) y_out <= -19'sd131072;
      else y_out <= 19'(acc);
    end else if (cmd.load) y_out <= 19'(xc);
  end

  assign num = cbe_pkg::DW'(diff) <<< cbe_pkg::FRAC;
  assign tn = (cbe_pkg::QW+1)'(t) - (cbe_pkg::QW+1)'(quo);
  assign sts.mul_done = mul_v;
  assign sts.div_done = div_done;
  assign sts.conv = ((acc - x) > -cbe_pkg::EPS) && ((acc - x) < cbe_pkg::EPS);
  assign sts.dzero = (acc == '0);

  cbe_div u_div (
    .clk(clk), .rst(rst), .go(cmd.div_go), .num(num), .den(acc),
    .done(div_done), .quo(quo)
  );

endmodule

// ===== src/cubic_bezier_easing_eval.sv =====
// Cubic Bezier easing: y_out = Y(t) with X(t) = x_in, end points (0,0) and (1,1),
// control points from the configuration registers (Q16). One word at a time:
// inputs at 0 or 1 (after clamp) go straight to the output; otherwise each Newton
// step is a curve pass, a convergence check, the derivative products, a check
// for a zero derivative and a bit-serial divide, up to 8 steps (the last one
// followed by one more curve pass), then a pass for Y. Input is held off until
// the result word is taken.
module cubic_bezier_easing_eval (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [17:0] x_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [18:0] y_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [18:0]        cfg_data
);

  logic [16:0] p1_x, p2_x;
  logic signed [18:0] p1_y, p2_y;
  cbe_pkg::cmd_t cmd;
  cbe_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_x <= '0;
      p1_y <= '0;
      p2_x <= 17'd65536;
      p2_y <= 19'sd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        cbe_pkg::REG_P1X: p1_x <= cfg_data[16:0];
        cbe_pkg::REG_P1Y: p1_y <= cfg_data;
        cbe_pkg::REG_P2X: p2_x <= cfg_data[16:0];
        cbe_pkg::REG_P2Y: p2_y <= cfg_data;
        default: ;
      endcase
    end
  end

  cbe_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  cbe_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .x_in(x_in),
    .p1_x(p1_x), .p1_y(p1_y), .p2_x(p2_x), .p2_y(p2_y), .y_out(y_out)
  );

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(y_out)) else $error("result dropped");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (y_out <= 19'sd131072) && (y_out >= -19'sd131072)) else $error("range");

endmodule

// ===== test/cubic_bezier_easing_eval_tb.sv =====
`timescale 1ns / 100ps

module cubic_bezier_easing_eval_tb;

  localparam int EASE_ONE = 65536;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [17:0] x_in;
  logic               out_valid;
  logic               out_ready;
  logic signed [18:0] y_out;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [18:0]        cfg_data;

  cubic_bezier_easing_eval uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .x_in(x_in),
    .out_valid(out_valid), .out_ready(out_ready), .y_out(y_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Curve predictor with its own copy of the control points.
  class ease_scoreboard;
    longint ctl_ax, ctl_ay, ctl_bx, ctl_by;
    logic signed [18:0] pending_y[$];
    int errors;
    int checked;

    function new();
      ctl_ax = 0;
      ctl_ay = 0;
      ctl_bx = EASE_ONE;
      ctl_by = EASE_ONE;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [18:0] data);
      logic signed [18:0] sdata;
      sdata = data;
      case (idx)
        cbe_pkg::REG_P1X: ctl_ax = longint'(data[16:0]);
        cbe_pkg::REG_P1Y: ctl_ay = longint'(sdata);
        cbe_pkg::REG_P2X: ctl_bx = longint'(data[16:0]);
        cbe_pkg::REG_P2Y: ctl_by = longint'(sdata);
        default: ;
      endcase
    endfunction

    // round to nearest, ties away from zero, by 16 bits
    function longint round16(longint v);
      if (v >= 0) return (v + 32768) >>> 16;
      return -((-v + 32768) >>> 16);
    endfunction

    function longint fmul(longint a, longint b);
      return round16(a * b);
    endfunction

    function longint curve(longint t, longint a, longint b);
      longint u, t2, k1, k2;
      u = EASE_ONE - t;
      t2 = fmul(t, t);
      k1 = fmul(fmul(u, u), t);
      k2 = fmul(u, t2);
      return 3 * fmul(k1, a) + 3 * fmul(k2, b) + fmul(t2, t);
    endfunction

    function void note_x(logic signed [17:0] xv);
      longint x, t, diff, u, d, y, tol;
      x = longint'(xv);
      if (x < 0) x = 0;
      if (x > EASE_ONE) x = EASE_ONE;
      if (x == 0 || x == EASE_ONE) begin
        pending_y.push_back(19'(x));
        return;
      end
      tol = (EASE_ONE + 500) / 1000;
      t = x;
      for (int i = 0; i < 8; i++) begin
        diff = curve(t, ctl_ax, ctl_bx) - x;
        if (diff > -tol && diff < tol) break;
        u = EASE_ONE - t;
        d = 3 * fmul(fmul(u, u), ctl_ax) + 6 * fmul(fmul(u, t), ctl_bx - ctl_ax)
          + 3 * fmul(fmul(t, t), EASE_ONE - ctl_bx);
        if (d == 0) break;
        t = t - (diff * EASE_ONE) / d;
        if (t < 0) t = 0;
        if (t > EASE_ONE) t = EASE_ONE;
      end
      y = curve(t, ctl_ay, ctl_by);
      if (y > 131072) y = 131072;
      if (y < -131072) y = -131072;
      pending_y.push_back(19'(y));
    endfunction

    function void check_y(logic signed [18:0] got);
      logic signed [18:0] want;
      if (pending_y.size() == 0) begin
        $error("y_out: no word expected, actual %0d", got);
        errors++;
        return;
      end
      want = pending_y.pop_front();
      checked++;
      if (got !== want) begin
        $error("y_out: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  ease_scoreboard sb;
  int sent;
  bit hold_off;
  bit sink_enable;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("cubic_bezier_easing_eval: mismatch");
    $finish;
  end

  // receiver: random stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst || !sink_enable) begin
      out_ready <= 1'b0;
    end else if (hold_off) begin
      out_ready <= 1'b0;
    end else begin
      case (sent % 3)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 1) != 0);
      endcase
    end
    if (!rst && out_valid && out_ready) sb.check_y(y_out);
  end

  // hold cfg_valid between back-to-back writes
  task automatic write_reg(logic [1:0] idx, logic [18:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
  endtask

  task automatic write_curve(logic [18:0] px1, logic [18:0] py1,
                             logic [18:0] px2, logic [18:0] py2);
    write_reg(cbe_pkg::REG_P1X, px1);
    write_reg(cbe_pkg::REG_P1Y, py1);
    write_reg(cbe_pkg::REG_P2X, px2);
    write_reg(cbe_pkg::REG_P2Y, py2);
    cfg_valid <= 1'b0;
  endtask

  // send one word; a gap is inserted only between bursts
  task automatic send_x(logic signed [17:0] xv, int gap);
    in_valid <= 1'b1;
    x_in <= xv;
    do @(posedge clk); while (!in_ready);
    sb.note_x(xv);
    sent++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_y.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [17:0] rand_x();
    case ($urandom_range(0, 9))
      0: return 18'($urandom);
      1: return 18'($urandom_range(0, 8));
      2: return 18'(EASE_ONE - $urandom_range(0, 8));
      default: return 18'($urandom_range(1, EASE_ONE - 1));
    endcase
  endfunction

  task automatic random_phase(int count);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) burst = $urandom_range(1, 12);
      burst--;
      send_x(rand_x(), (burst == 0 && ($urandom_range(0, 3) != 0))
                       ? $urandom_range(1, 40) : 0);
    end
  endtask

  initial begin
    logic [18:0] px1, py1, px2, py2;
    clk = 1'b0;
    sb = new();
    sent = 0;
    hold_off = 1'b0;
    sink_enable = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    x_in = '0;
    cfg_valid = 1'b0;
    cfg_index = cbe_pkg::REG_P1X;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    sink_enable <= 1'b1;
    @(posedge clk);

    // directed: reset curve first, then extremes of the control points
    send_x(18'sh20000, 0);
    send_x(18'sh1ffff, 0);
    send_x(18'sd0, 0);
    send_x(18'sd65536, 0);
    send_x(18'sd1, 0);
    send_x(18'sd65535, 0);
    send_x(18'sd32768, 0);
    send_x(-18'sd1, 0);
    send_x(18'sd65537, 3);
    drain();
    write_curve(19'd65536, 19'h40000, 19'd0, 19'd131072);
    send_x(18'sd100, 0);
    send_x(18'sd32768, 0);
    send_x(18'sd60000, 0);
    drain();
    // control X above one, and a flat-derivative curve
    write_curve(19'h1ffff, 19'h7ffff, 19'h1ffff, 19'h3ffff);
    send_x(18'sd20000, 0);
    send_x(18'sd50000, 0);
    drain();
    write_curve(19'd0, 19'd131072, 19'd65536, 19'h60000);
    send_x(18'sd1, 0);
    send_x(18'sd32768, 0);
    send_x(18'sd65535, 0);
    drain();

    // long receiver hold-off while the sender keeps offering words
    fork
      begin
        hold_off <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_off <= 1'b0;
      end
      random_phase(20);
    join
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      px1 = 19'($urandom_range(0, 131071));
      py1 = 19'($urandom);
      px2 = 19'($urandom_range(0, 131071));
      py2 = 19'($urandom);
      if (ph % 3 != 2) begin
        px1 = 19'($urandom_range(0, EASE_ONE));
        px2 = 19'($urandom_range(0, EASE_ONE));
        py1 = 19'($signed(19'($urandom_range(0, 262144))) - 19'sd131072);
        py2 = 19'($signed(19'($urandom_range(0, 262144))) - 19'sd131072);
      end
      write_curve(px1, py1, px2, py2);
      random_phase(100);
      drain();
    end

    $display("covered %0d words over 13 control-point settings, %0d results checked",
             sent, sb.checked);
    $display("including clamp, end points, wide control points and a long output stall");
    if (sb.errors == 0 && sb.pending_y.size() == 0) begin
      $display("cubic_bezier_easing_eval: match");
    end else begin
      $display("cubic_bezier_easing_eval: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/cbe_pkg.sv
src/cbe_ctrl.sv
src/cbe_div.sv
src/cbe_dp.sv
src/cubic_bezier_easing_eval.sv
test/cubic_bezier_easing_eval_tb.sv
